/* hdl/mbe_pkg.sv */
// Shared types and constants for the Mandelbrot escape-time pixel unit.
// No dependencies; used by every other file in hdl/ except mbe_div.
package mbe_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned ITER_LIMIT_DEF = 1000;
    localparam int unsigned FRAC_BITS_DEF  = 28;
    localparam int unsigned MAX_DIM_DEF    = 4096;

    // Fixed field widths
    localparam int unsigned COORD_W = 12;
    localparam int unsigned DIM_W   = 13;
    localparam int unsigned CHAN_W  = 8;

    // Colour scaling steps after the iteration ends
    localparam int unsigned COLOR_STEPS = 1;

    localparam logic [DIM_W-1:0] DIM_RESET = 13'd1000;

    // Configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;
        logic div_step;
        logic iter_step;
        logic color_load;
        logic color_step;
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic iter_done;
    } status_t;

endpackage

/* hdl/mbe_div.sv */
// Restoring shift-subtract divider, one quotient bit per cycle while step is high.
// quo = floor(num * 2^Q_W / (den << PRE)); needs num < den << PRE. No dependencies.
module mbe_div #(
    parameter int unsigned NUM_W = 15,
    parameter int unsigned DEN_W = 14,
    parameter int unsigned Q_W   = 31,
    parameter int unsigned PRE   = 3
) (
    input  logic             clk,
    input  logic             load,
    input  logic             step,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    localparam int unsigned RW = DEN_W + PRE + 1;
    localparam int unsigned EW = (NUM_W > RW) ? NUM_W : RW;

    logic [RW-1:0]  rem_reg;
    logic [RW-1:0]  dsh_reg;
    logic [Q_W-1:0] quo_reg;
    logic [EW-1:0]  num_ext;
    logic [RW-1:0]  rem_sh;
    logic           ge;

    assign num_ext = EW'(num);
    assign rem_sh  = {rem_reg[RW-2:0], 1'b0};
    assign ge      = (rem_sh >= dsh_reg);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= num_ext[RW-1:0];
            dsh_reg <= RW'({den, {PRE{1'b0}}});
            quo_reg <= '0;
        end
        else if (step)
        begin
            rem_reg <= ge ? (rem_sh - dsh_reg) : rem_sh;
            quo_reg <= {quo_reg[Q_W-2:0], ge};
        end
    end

    assign quo = quo_reg;

endmodule

/* hdl/mbe_datapath.sv */
// Datapath: config registers, coordinate dividers, z iteration, colour scaling.
// Depends on mbe_pkg and mbe_div.
module mbe_datapath #(
    parameter int unsigned ITER_LIMIT = mbe_pkg::ITER_LIMIT_DEF,
    parameter int unsigned FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF,
    parameter int unsigned MAX_DIM    = mbe_pkg::MAX_DIM_DEF,
    localparam int unsigned CW        = $clog2(ITER_LIMIT + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic                         cfg_index,
    input  logic [mbe_pkg::DIM_W-1:0]    cfg_data,
    input  logic [mbe_pkg::COORD_W-1:0]  col,
    input  logic [mbe_pkg::COORD_W-1:0]  row,
    input  mbe_pkg::cmd_t                cmd,
    output mbe_pkg::status_t             status,
    output logic [CW-1:0]                escape_count,
    output logic [mbe_pkg::CHAN_W-1:0]   green,
    output logic [mbe_pkg::CHAN_W-1:0]   blue
);

    localparam int unsigned DW = mbe_pkg::DIM_W;
    localparam int unsigned F  = FRAC_BITS;
    localparam int unsigned VW = F + 5;      // signed z value, |z| < 16
    localparam int unsigned MW = F + 4;      // magnitude of a z component
    localparam int unsigned PW = 2 * MW;     // full product
    localparam int unsigned SW = F + 8;      // product after truncation
    localparam int unsigned WW = F + 10;     // update sums before truncation
    localparam int unsigned QW = F + 3;      // coordinate quotient bits

    localparam int unsigned DIM_TOP = (1 << DW) - 1;
    localparam int unsigned DIM_CAP = (MAX_DIM > DIM_TOP) ? DIM_TOP : MAX_DIM;
    localparam logic [DW-1:0] CAP   = DW'(DIM_CAP);

    localparam logic [MW-1:0]        SAT_FIX = MW'(8) << F;
    localparam logic signed [VW-1:0] X_OFF   = VW'(5) << (F - 1);
    localparam logic signed [VW-1:0] Y_OFF   = VW'(1) << F;
    localparam logic [SW:0]          FOUR    = (SW + 1)'(4) << F;
    localparam logic [CW-1:0]        LIMIT_C  = CW'(ITER_LIMIT);
    localparam logic [CW-1:0]        LIMIT_M1 = CW'(ITER_LIMIT - 1);

    // colour scaling: x / limit as (x * ceil(2^RK / limit)) >> RK, exact for
    // x below 2^GN_W since the rounding error times x stays under 2^RK
    localparam int unsigned GN_W = CW + 8;
    localparam int unsigned RK   = GN_W + CW;
    localparam int unsigned RM_W = GN_W + 2;
    localparam longint unsigned RECIP_V =
        ((64'd1 << RK) + 64'(ITER_LIMIT) - 64'd1) / 64'(ITER_LIMIT);
    localparam logic [RM_W-1:0] RECIP = RM_W'(RECIP_V);

    // configuration
    logic [DW-1:0] width_reg;
    logic [DW-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mbe_pkg::DIM_RESET;
            height_reg <= mbe_pkg::DIM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mbe_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                mbe_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    // zero counts as one, oversize clamps to the cap
    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;

    assign w_eff = (width_reg == '0) ? DW'(1) : ((width_reg > CAP) ? CAP : width_reg);
    assign h_eff = (height_reg == '0) ? DW'(1) : ((height_reg > CAP) ? CAP : height_reg);

    // real: col*7 / (2w), imag: row*2 / h
    logic [14:0]   x_num;
    logic [DW:0]   x_den;
    logic [12:0]   y_num;
    logic          x_sat_next;
    logic          y_sat_next;
    logic          x_sat_reg;
    logic          y_sat_reg;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;

    assign x_num      = ({3'b000, col} << 3) - {3'b000, col};
    assign x_den      = {w_eff, 1'b0};
    assign y_num      = {row, 1'b0};
    assign x_sat_next = ({2'b00, x_num} >= {x_den, 3'b000});
    assign y_sat_next = ({3'b000, y_num} >= {h_eff, 3'b000});

    mbe_div #(.NUM_W(15), .DEN_W(DW + 1), .Q_W(QW), .PRE(3)) u_xdiv (
        .clk  (clk),
        .load (cmd.load),
        .step (cmd.div_step),
        .num  (x_num),
        .den  (x_den),
        .quo  (qx)
    );

    mbe_div #(.NUM_W(13), .DEN_W(DW), .Q_W(QW), .PRE(3)) u_ydiv (
        .clk  (clk),
        .load (cmd.load),
        .step (cmd.div_step),
        .num  (y_num),
        .den  (h_eff),
        .quo  (qy)
    );

    logic [MW-1:0]        qx_fix;
    logic [MW-1:0]        qy_fix;
    logic signed [VW-1:0] x0;
    logic signed [VW-1:0] y0;

    assign qx_fix = x_sat_reg ? SAT_FIX : {1'b0, qx};
    assign qy_fix = y_sat_reg ? SAT_FIX : {1'b0, qy};
    assign x0     = $signed({1'b0, qx_fix}) - X_OFF;
    assign y0     = $signed({1'b0, qy_fix}) - Y_OFF;

    // one z = z*z + c step per cycle while iter_step is high and the iteration is not done
    logic signed [VW-1:0] x_reg;
    logic signed [VW-1:0] y_reg;
    logic [CW-1:0]        n_reg;
    logic [VW-1:0]        x_neg;
    logic [VW-1:0]        y_neg;
    logic [MW-1:0]        ax;
    logic [MW-1:0]        ay;
    logic [PW-1:0]        pxx;
    logic [PW-1:0]        pyy;
    logic [PW-1:0]        pxy;
    logic [SW-1:0]        xx;
    logic [SW-1:0]        yy;
    logic [SW-1:0]        mxy;
    logic [WW-1:0]        m2;
    logic [WW-1:0]        x_wide;
    logic [WW-1:0]        y_wide;
    logic                 neg;
    logic                 esc;
    logic                 iter_done;

    assign x_neg = -x_reg;
    assign y_neg = -y_reg;
    assign ax    = x_reg[VW-1] ? x_neg[MW-1:0] : x_reg[MW-1:0];
    assign ay    = y_reg[VW-1] ? y_neg[MW-1:0] : y_reg[MW-1:0];
    assign pxx   = ax * ax;
    assign pyy   = ay * ay;
    assign pxy   = ax * ay;
    assign xx    = pxx[PW-1:F];
    assign yy    = pyy[PW-1:F];
    assign mxy   = pxy[PW-1:F];
    assign neg   = x_reg[VW-1] ^ y_reg[VW-1];
    assign esc   = ({1'b0, xx} + {1'b0, yy}) > FOUR;
    assign m2    = {1'b0, mxy, 1'b0};

    assign x_wide = {2'b00, xx} - {2'b00, yy} + {{5{x0[VW-1]}}, x0};
    assign y_wide = (neg ? -m2 : m2) + {{5{y0[VW-1]}}, y0};

    assign iter_done        = esc || (n_reg == LIMIT_C);
    assign status.iter_done = iter_done;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_sat_reg <= x_sat_next;
            y_sat_reg <= y_sat_next;
            x_reg     <= '0;
            y_reg     <= '0;
        end
        else if (cmd.iter_step && !iter_done)
        begin
            x_reg <= x_wide[VW-1:0];
            y_reg <= y_wide[VW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
        end
        else if (cmd.load)
        begin
            n_reg <= '0;
        end
        else if (cmd.iter_step && !iter_done)
        begin
            n_reg <= n_reg + CW'(1);
        end
    end

    // colour: nc*255/limit and nc*nc*255/limit, blue zero when nc*nc exceeds limit
    logic [CW-1:0]          nc;
    logic [2*CW-1:0]        sq;
    logic                   blue_ok;
    logic [GN_W-1:0]        g_num;
    logic [GN_W-1:0]        b_num;
    logic [GN_W-1:0]        g_num_reg;
    logic [GN_W-1:0]        b_num_reg;
    logic [GN_W+RM_W-1:0]   g_prod;
    logic [GN_W+RM_W-1:0]   b_prod;
    logic [mbe_pkg::CHAN_W-1:0] green_reg;
    logic [mbe_pkg::CHAN_W-1:0] blue_reg;

    assign nc      = (n_reg == LIMIT_C) ? LIMIT_M1 : n_reg;
    assign sq      = nc * nc;
    assign blue_ok = (sq <= {{CW{1'b0}}, LIMIT_C});
    assign g_num   = {nc, 8'h00} - {8'h00, nc};
    assign b_num   = blue_ok ? ({sq[CW-1:0], 8'h00} - {8'h00, sq[CW-1:0]}) : '0;
    assign g_prod  = g_num_reg * RECIP;
    assign b_prod  = b_num_reg * RECIP;

    // numerators latch as the iteration ends, quotients in the cycle after
    always_ff @(posedge clk)
    begin
        if (cmd.color_load)
        begin
            g_num_reg <= g_num;
            b_num_reg <= b_num;
        end
        if (cmd.color_step)
        begin
            green_reg <= g_prod[RK +: mbe_pkg::CHAN_W];
            blue_reg  <= b_prod[RK +: mbe_pkg::CHAN_W];
        end
    end

    assign green        = green_reg;
    assign blue         = blue_reg;
    assign escape_count = n_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.iter_step |-> (n_reg <= LIMIT_C))
        else $error("iteration count past limit");
    a_color_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.color_load |-> (esc || (n_reg == LIMIT_C)))
        else $error("colour started before iteration finished");
`endif

endmodule

/* hdl/mbe_ctrl.sv */
// Controller FSM: sequences load, coordinate divide, iteration, colour, output.
// Depends on mbe_pkg.
module mbe_ctrl #(
    parameter int unsigned FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  mbe_pkg::status_t status,
    output mbe_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done
);

    localparam int unsigned CNT_W = $clog2(FRAC_BITS + 3);
    localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(FRAC_BITS + 2);
    localparam logic [CNT_W-1:0] COLOR_LAST = CNT_W'(mbe_pkg::COLOR_STEPS - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_ITER  = 5'b00100,
        ST_COLOR = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_ITER;
                end
            end
            ST_ITER:
            begin
                cmd.iter_step = 1'b1;
                if (status.iter_done)
                begin
                    cmd.color_load = 1'b1;
                    cnt_next       = '0;
                    state_next     = ST_COLOR;
                end
            end
            ST_COLOR:
            begin
                cmd.color_step = 1'b1;
                cnt_next       = cnt_reg + CNT_W'(1);
                if (cnt_reg == COLOR_LAST)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_OUT);

`ifndef SYNTHESIS
    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("done not followed by idle");
    a_done_after_color: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(cmd.color_step))
        else $error("result without colour phase");
`endif

endmodule

/* hdl/mandelbrot_escape_pixel_unit.sv */
// Top level of the Mandelbrot escape-time pixel unit.
// Depends on mbe_pkg, mbe_ctrl, mbe_datapath (and mbe_div below it).
//
// Usage:
//   A pixel transaction is taken at a rising edge with start high and busy
//   low; col/row are sampled at that edge only. busy stays high until the
//   result has been presented.
//   The result (escape_count, red, green, blue) is valid for exactly one
//   cycle while done is high; the receiver cannot stall, so it must take it
//   in that cycle. The result ports hold their value until the next pixel.
//   After the accept edge the coordinate dividers run bit-serially, then the
//   single z*z+c iteration unit takes one step per cycle until the point
//   escapes or reaches ITER_LIMIT; reciprocal-multiply colour scaling and
//   an output state follow, with done high in the output state; busy drops
//   the cycle after done.
//   One pixel is in flight at a time.
//   Config: cfg_write/cfg_index/cfg_data write image_width (index 0) or
//   image_height (index 1) at a rising edge; write only while busy is low.
//   Reset (rst_n low, async) returns to idle and sets both sizes to 1000.
module mandelbrot_escape_pixel_unit #(
    parameter int unsigned ITER_LIMIT = mbe_pkg::ITER_LIMIT_DEF,
    parameter int unsigned FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF,
    parameter int unsigned MAX_DIM    = mbe_pkg::MAX_DIM_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // config write port
    input  logic                                 cfg_write,
    input  logic                                 cfg_index,
    input  logic [mbe_pkg::DIM_W-1:0]            cfg_data,
    // pixel command
    input  logic                                 start,
    output logic                                 busy,
    input  logic [mbe_pkg::COORD_W-1:0]          col,
    input  logic [mbe_pkg::COORD_W-1:0]          row,
    // result strobe
    output logic                                 done,
    output logic [$clog2(ITER_LIMIT + 1)-1:0]    escape_count,
    output logic [mbe_pkg::CHAN_W-1:0]           red,
    output logic [mbe_pkg::CHAN_W-1:0]           green,
    output logic [mbe_pkg::CHAN_W-1:0]           blue
);

    mbe_pkg::cmd_t    cmd;
    mbe_pkg::status_t status;

    // sequencing
    mbe_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // arithmetic and config storage
    mbe_datapath #(
        .ITER_LIMIT (ITER_LIMIT),
        .FRAC_BITS  (FRAC_BITS),
        .MAX_DIM    (MAX_DIM)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .col          (col),
        .row          (row),
        .cmd          (cmd),
        .status       (status),
        .escape_count (escape_count),
        .green        (green),
        .blue         (blue)
    );

    // red channel is always dark
    assign red = '0;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for mandelbrot_escape_pixel_unit.
// Depends on mbe_pkg and the RTL in hdl/; an internal bit-exact escape-time
// predictor feeds a small scoreboard class.

typedef struct packed {
    logic [9:0] count;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
} pixel_result_t;

class pixel_scoreboard;
    pixel_result_t pending[$];
    int unsigned   n_errors;
    int unsigned   n_checked;

    function void note_pixel(pixel_result_t exp_res);
        pending.push_back(exp_res);
    endfunction

    function void check_pixel(logic [9:0] count, logic [7:0] r, logic [7:0] g,
                              logic [7:0] b);
        pixel_result_t e;
        if (pending.size() == 0) begin
            $error("result with no pixel outstanding: count %0d", count);
            n_errors++;
            return;
        end
        e = pending.pop_front();
        n_checked++;
        if (count !== e.count) begin
            $error("escape_count: expected %0d, got %0d", e.count, count);
            n_errors++;
        end
        if (r !== e.r) begin
            $error("red: expected %0d, got %0d", e.r, r);
            n_errors++;
        end
        if (g !== e.g) begin
            $error("green: expected %0d, got %0d", e.g, g);
            n_errors++;
        end
        if (b !== e.b) begin
            $error("blue: expected %0d, got %0d", e.b, b);
            n_errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int unsigned LIMIT  = mbe_pkg::ITER_LIMIT_DEF;
    localparam int unsigned FRAC   = mbe_pkg::FRAC_BITS_DEF;
    localparam int unsigned MAXD   = mbe_pkg::MAX_DIM_DEF;
    localparam int unsigned CRD_W  = mbe_pkg::COORD_W;
    localparam int unsigned DIM_W  = mbe_pkg::DIM_W;
    localparam int unsigned CHAN_W = mbe_pkg::CHAN_W;
    // settle margin after the last pixel, sized from FRAC and LIMIT
    localparam int unsigned DRAIN_CYCLES = FRAC + LIMIT + 40;
    localparam longint unsigned CYCLE_LIMIT = 3_000_000;
    localparam logic [63:0] SAT_MAG = 64'd1 << 62;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic                cfg_index = mbe_pkg::CFG_IMAGE_WIDTH;
    logic [DIM_W-1:0]    cfg_data = '0;
    logic                start = 1'b0;
    logic                busy;
    logic [CRD_W-1:0]    col = '0;
    logic [CRD_W-1:0]    row = '0;
    logic                done;
    logic [9:0]          escape_count;
    logic [CHAN_W-1:0]   red, green, blue;

    pixel_scoreboard     sb;
    longint unsigned     cycle_cnt = 0;
    int unsigned         idle_pct = 0;      // sender gap probability, percent
    logic [DIM_W-1:0]    width_q = mbe_pkg::DIM_RESET;
    logic [DIM_W-1:0]    height_q = mbe_pkg::DIM_RESET;
    int unsigned         n_sent = 0;

    mandelbrot_escape_pixel_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .col          (col),
        .row          (row),
        .done         (done),
        .escape_count (escape_count),
        .red          (red),
        .green        (green),
        .blue         (blue)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: fixed point with FRAC fraction bits, magnitudes truncated.
    // ------------------------------------------------------------------
    function automatic logic [63:0] mag_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        logic [127:0] s;
        p = a * b;
        s = p >> FRAC;
        if (s > {64'd0, SAT_MAG})
            return SAT_MAG;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] signed_mul(logic signed [63:0] a,
                                                     logic signed [63:0] b);
        logic [63:0] m;
        m = mag_mul(a < 0 ? -a : a, b < 0 ? -b : b);
        return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
    endfunction

    // floor(num * 2^FRAC / den), clamped at 8.0
    function automatic logic signed [63:0] coord_ratio(logic [63:0] num,
                                                      logic [63:0] den);
        logic [127:0] q;
        if (num / den >= 8)
            return 64'sd8 <<< FRAC;
        q = ({64'd0, num} << FRAC) / den;
        return $signed(q[63:0]);
    endfunction

    function automatic logic [63:0] eff_dim(logic [DIM_W-1:0] v);
        if (v == '0)
            return 64'd1;
        return (v > MAXD) ? 64'(MAXD) : 64'(v);
    endfunction

    function automatic pixel_result_t escape_pixel(
            logic [CRD_W-1:0] c, logic [CRD_W-1:0] r);
        pixel_result_t res;
        logic signed [63:0] cx, cy, zx, zy, xt;
        logic [63:0] xx, yy, nc;
        int unsigned n;
        cx = coord_ratio(c * 64'd7, 2 * eff_dim(width_q)) - (64'sd5 <<< (FRAC - 1));
        cy = coord_ratio(r * 64'd2, eff_dim(height_q)) - (64'sd1 <<< FRAC);
        zx = 0;
        zy = 0;
        n = 0;
        while (n < LIMIT) begin
            xx = mag_mul(zx < 0 ? -zx : zx, zx < 0 ? -zx : zx);
            yy = mag_mul(zy < 0 ? -zy : zy, zy < 0 ? -zy : zy);
            if (xx + yy > (64'd4 << FRAC))
                break;
            xt = $signed(xx) - $signed(yy) + cx;
            zy = 2 * signed_mul(zx, zy) + cy;
            zx = xt;
            n++;
        end
        nc = (n >= LIMIT) ? 64'(LIMIT - 1) : 64'(n);
        res.count = n[9:0];
        res.r = '0;
        res.g = 8'(nc * 255 / LIMIT);
        res.b = (nc * nc <= LIMIT) ? 8'(nc * nc * 255 / LIMIT) : 8'd0;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Drivers: inputs move on the falling edge only.
    // ------------------------------------------------------------------
    task automatic write_reg(logic idx, logic [DIM_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == mbe_pkg::CFG_IMAGE_WIDTH)
            width_q = val;
        else
            height_q = val;
    endtask

    // Drops start, waits for every outstanding result, then lets the unit settle.
    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One pixel transaction; start stays high until an edge takes it and
    // is left high for a following back-to-back pixel.
    task automatic send_pixel(logic [CRD_W-1:0] c, logic [CRD_W-1:0] r);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < idle_pct)
                @(negedge clk);
        end
        start <= 1'b1;
        col   <= c;
        row   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_pixel(escape_pixel(c, r));
        n_sent++;
        @(negedge clk);
    endtask

    // Pixels mostly inside the image, sometimes anywhere in the field range.
    task automatic send_random(int unsigned count);
        logic [CRD_W-1:0] c, r;
        int unsigned wd, ht;
        wd = 32'(eff_dim(width_q));
        ht = 32'(eff_dim(height_q));
        repeat (count) begin
            if ($urandom_range(9) == 0) begin
                c = CRD_W'($urandom);
                r = CRD_W'($urandom);
            end else begin
                c = CRD_W'($urandom_range(wd - 1));
                r = CRD_W'($urandom_range(ht - 1));
            end
            send_pixel(c, r);
        end
    endtask

    // Results are checked on the rising edge that ends the done cycle.
    always @(posedge clk) begin
        if (rst_n && done)
            sb.check_pixel(escape_count, red, green, blue);
    end

    // Timeout watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [DIM_W-1:0] dims[6];
        sb = new();
        dims = '{13'd1, 13'd2, 13'd4096, 13'd8191, 13'd0, 13'd37};
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset sizes, corners, center of the main cardioid
        // (never escapes), the far field, and all-ones coordinates.
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd999, 12'd999);
        send_pixel(12'd714, 12'd500);     // c near 0: runs to the limit
        send_pixel(12'd500, 12'd500);
        send_pixel(12'd4095, 12'd4095);   // outside image, saturated ratio
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd2730, 12'd1365);
        send_pixel(12'd1365, 12'd2730);
        send_pixel(12'd571, 12'd500);     // c near -0.5
        send_pixel(12'd428, 12'd500);     // c near -1
        wait_drained();

        // Odd and zero / oversized sizes.
        foreach (dims[i]) begin
            write_reg(mbe_pkg::CFG_IMAGE_WIDTH, dims[i]);
            write_reg(mbe_pkg::CFG_IMAGE_HEIGHT, dims[5 - i]);
            send_pixel(12'd0, 12'd0);
            send_pixel(12'd4095, 12'd4095);
            send_pixel(CRD_W'($urandom), CRD_W'($urandom));
            wait_drained();
        end

        // Random phases; sender pressure varies, receiver cannot stall.
        write_reg(mbe_pkg::CFG_IMAGE_WIDTH, 13'd64);
        write_reg(mbe_pkg::CFG_IMAGE_HEIGHT, 13'd48);
        idle_pct = 0;
        send_random(150);
        wait_drained();     // sender holds off until all results are in

        write_reg(mbe_pkg::CFG_IMAGE_WIDTH, 13'd4096);
        write_reg(mbe_pkg::CFG_IMAGE_HEIGHT, 13'd4096);
        idle_pct = 85;
        send_random(150);
        wait_drained();

        write_reg(mbe_pkg::CFG_IMAGE_WIDTH, DIM_W'($urandom_range(1, 8191)));
        write_reg(mbe_pkg::CFG_IMAGE_HEIGHT, DIM_W'($urandom_range(1, 8191)));
        idle_pct = 21;
        send_random(150);
        wait_drained();

        write_reg(mbe_pkg::CFG_IMAGE_WIDTH, 13'd1000);
        write_reg(mbe_pkg::CFG_IMAGE_HEIGHT, 13'd1000);
        idle_pct = 0;
        send_random(150);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d pixels over several image sizes, %0d results checked",
                 n_sent, sb.n_checked);
        if (sb.n_errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.n_errors,
                     sb.pending.size());
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
